// ===== sv/set_assoc_lru_tag_store_unit_macros.svh =====
// assertion macros for the tag store
`ifndef SET_ASSOC_LRU_TAG_STORE_UNIT_MACROS_SVH
`define SET_ASSOC_LRU_TAG_STORE_UNIT_MACROS_SVH
`ifndef ASSERT_OFF
`define SALT_ASSERT(label, clk, rst_n, prop, msg) \
  label: assert property (@(posedge clk) disable iff (!rst_n) (prop)) else $error(msg);
`define SALT_ASSERT_NEXT(label, clk, rst_n, pre, post, msg) \
  label: assert property (@(posedge clk) disable iff (!rst_n) (pre) |=> (post)) else $error(msg);
`else
`define SALT_ASSERT(label, clk, rst_n, prop, msg)
`define SALT_ASSERT_NEXT(label, clk, rst_n, pre, post, msg)
`endif
`endif

// ===== sv/salts_pkg.sv =====
package salts_pkg;

  typedef enum logic [1:0] {
    ACT_ACCESS = 2'd0,
    ACT_FILL   = 2'd1,
    ACT_INVAL  = 2'd2,
    ACT_CLEAN  = 2'd3
  } action_e;

  typedef enum logic [2:0] {
    ST_IDLE,
    ST_CLEAR,
    ST_READ,
    ST_SCAN,
    ST_WRITE,
    ST_OUT
  } state_e;

endpackage

// ===== sv/set_assoc_lru_tag_store_unit.sv =====
// Tag store of a write-back set-associative cache with timestamp LRU.
// Input channel: in_valid_i / in_stall_o carry one operation (access, fill,
// invalidate, clean) with address, time stamp and clean coordinates.
// Output channel: out_valid_o / out_stall_i carry one result per operation:
// hit, reported line address, fill error, dirty count, last dirty set/way.
// Line metadata lives in one memory with a single read and a single write
// port; each access, fill or invalidate reads the ways of its set one per
// cycle in ST_SCAN and then writes the chosen way in ST_WRITE, while clean
// reads only the line that its coordinates name in ST_READ and writes it
// back. A new operation is accepted only in ST_IDLE.
// The result sits in an output register; the next transaction is accepted
// once that register has been handed over, and the block holds its result
// for as long as out_stall_i stays high.
// After reset the block sweeps all NUM_SETS * NUM_WAYS lines of the store
// (512 by default) to clear valid and dirty bits, with in_stall_o high
// meanwhile.
`include "set_assoc_lru_tag_store_unit_macros.svh"
module set_assoc_lru_tag_store_unit
  import salts_pkg::*;
#(
  parameter int NUM_SETS    = 64,
  parameter int NUM_WAYS    = 8,
  parameter int OFFSET_BITS = 6,
  parameter int INDEX_BITS  = 6
) (
  input  logic               clk_i,
  input  logic               rst_ni,
  input  logic               in_valid_i,
  output logic               in_stall_o,
  input  logic [1:0]         action_i,
  input  logic               is_write_i,
  input  logic [31:0]        address_i,
  input  logic [31:0]        now_i,
  input  logic [5:0]         clean_set_i,
  input  logic [2:0]         clean_way_i,
  output logic               out_valid_o,
  input  logic               out_stall_i,
  output logic               hit_o,
  output logic               line_valid_o,
  output logic [31:0]        line_address_o,
  output logic               fill_error_o,
  output logic signed [31:0] dirty_total_o,
  output logic [5:0]         last_dirty_set_o,
  output logic [2:0]         last_dirty_way_o
);

  localparam int SW     = (NUM_SETS > 1) ? $clog2(NUM_SETS) : 1;
  localparam int WW     = (NUM_WAYS > 1) ? $clog2(NUM_WAYS) : 1;
  localparam int LINES  = NUM_SETS * NUM_WAYS;
  localparam int LW     = (LINES > 1) ? $clog2(LINES) : 1;
  localparam int TAG_LO = OFFSET_BITS + INDEX_BITS;
  localparam int TW     = 32 - TAG_LO;
  localparam int IW     = (INDEX_BITS > 0) ? INDEX_BITS : 1;

  typedef struct packed {
    logic          valid;
    logic          dirty;
    logic [TW-1:0] tag;
    logic [31:0]   addr;
    logic [31:0]   stamp;
  } entry_t;

  entry_t mem_q [LINES];
  entry_t rd_q;

  state_e state_q, state_d;
  logic [LW-1:0] clr_q, clr_d;
  logic [WW:0] way_q, way_d;
  logic [WW-1:0] sel_q, sel_d;
  logic found_q, found_d;
  logic hitf_q, hitf_d;
  logic [31:0] best_q, best_d;
  logic [1:0] act_q;
  logic wr_q;
  logic [31:0] addr_q, now_q;
  logic [5:0] cset_q;
  logic [2:0] cway_q;
  logic [SW-1:0] set_q;

  logic hit_q, lv_q, ferr_q;
  logic [31:0] la_q, la_d;
  logic hit_d, lv_d, ferr_d;
  logic [31:0] cnt_q, cnt_d;
  logic [5:0] rset_q, rset_d;
  logic [2:0] rway_q, rway_d;
  logic ov_q, ov_d;

  logic we, re;
  logic [LW-1:0] waddr, raddr;
  entry_t wdata;
  logic [SW-1:0] in_set;
  logic [IW-1:0] idx_bits;

  function automatic logic [LW-1:0] line_of(input logic [SW-1:0] s, input logic [WW-1:0] w);
    return LW'(s * NUM_WAYS + w);
  endfunction

  if (INDEX_BITS > 0) begin : g_idx
    assign idx_bits = address_i[OFFSET_BITS +: IW];
  end else begin : g_noidx
    assign idx_bits = '0;
  end
  assign in_set = SW'(32'(idx_bits) % NUM_SETS);

  logic accept;
  assign accept = in_valid_i && !in_stall_o;
  assign in_stall_o = (state_q != ST_IDLE) || (ov_q && out_stall_i);

  always_ff @(posedge clk_i) begin
    if (we) mem_q[waddr] <= wdata;
    if (re) rd_q <= mem_q[raddr];
  end

  always_ff @(posedge clk_i) begin
    if (accept) begin
      act_q  <= action_i;
      wr_q   <= is_write_i;
      addr_q <= address_i;
      now_q  <= now_i;
      cset_q <= clean_set_i;
      cway_q <= clean_way_i;
      set_q  <= in_set;
    end
  end

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      state_q <= ST_CLEAR;
      clr_q   <= '0;
      way_q   <= '0;
      sel_q   <= '0;
      found_q <= 1'b0;
      hitf_q  <= 1'b0;
      best_q  <= '0;
      hit_q   <= 1'b0;
      lv_q    <= 1'b0;
      ferr_q  <= 1'b0;
      la_q    <= '0;
      cnt_q   <= '0;
      rset_q  <= '0;
      rway_q  <= '0;
      ov_q    <= 1'b0;
    end else begin
      state_q <= state_d;
      clr_q   <= clr_d;
      way_q   <= way_d;
      sel_q   <= sel_d;
      found_q <= found_d;
      hitf_q  <= hitf_d;
      best_q  <= best_d;
      hit_q   <= hit_d;
      lv_q    <= lv_d;
      ferr_q  <= ferr_d;
      la_q    <= la_d;
      cnt_q   <= cnt_d;
      rset_q  <= rset_d;
      rway_q  <= rway_d;
      ov_q    <= ov_d;
    end
  end

  logic [WW-1:0] cur_way;
  logic tag_match;
  assign cur_way = way_q[WW-1:0];
  assign tag_match = rd_q.valid && (rd_q.tag == addr_q[31:TAG_LO]);

  always_comb begin
    state_d = state_q;
    clr_d   = clr_q;
    way_d   = way_q;
    sel_d   = sel_q;
    found_d = found_q;
    hitf_d  = hitf_q;
    best_d  = best_q;
    hit_d   = hit_q;
    lv_d    = lv_q;
    ferr_d  = ferr_q;
    la_d    = la_q;
    cnt_d   = cnt_q;
    rset_d  = rset_q;
    rway_d  = rway_q;
    ov_d    = ov_q && out_stall_i;
    we      = 1'b0;
    re      = 1'b0;
    waddr   = line_of(set_q, sel_q);
    raddr   = line_of(set_q, cur_way);
    wdata   = rd_q;

    unique case (state_q)
      ST_CLEAR: begin
        we = 1'b1;
        waddr = clr_q;
        wdata = '{valid: 1'b0, dirty: 1'b0, tag: '1, addr: '0, stamp: '0};
        clr_d = clr_q + 1'b1;
        if (clr_q == LW'(LINES - 1)) state_d = ST_IDLE;
      end
      ST_IDLE: begin
        if (accept) begin
          way_d   = '0;
          found_d = 1'b0;
          hitf_d  = 1'b0;
          best_d  = now_i;
          sel_d   = '0;
          if (action_i == ACT_CLEAN) begin
            state_d = ST_READ;
          end else begin
            state_d = ST_SCAN;
            re = 1'b1;
            raddr = line_of(in_set, '0);
          end
        end
      end
      // clean: read the line, then write it back with the dirty bit off (out-of-range coordinates give a result only)
      ST_READ: begin
        if (act_q == ACT_CLEAN && !hitf_q) begin
          if (32'(cset_q) < NUM_SETS && 32'(cway_q) < NUM_WAYS) begin
            re = 1'b1;
            raddr = LW'(32'(cset_q) * NUM_WAYS + 32'(cway_q));
            hitf_d = 1'b1;
          end else begin
            hit_d = 1'b0; lv_d = 1'b0; la_d = '0; ferr_d = 1'b0;
            ov_d = 1'b1;
            state_d = ST_OUT;
          end
        end else begin
          we = 1'b1;
          waddr = LW'(32'(cset_q) * NUM_WAYS + 32'(cway_q));
          wdata = rd_q;
          wdata.dirty = 1'b0;
          hit_d = 1'b0; lv_d = 1'b0; la_d = '0; ferr_d = 1'b0;
          ov_d = 1'b1;
          state_d = ST_OUT;
        end
      end
      // one way per cycle: rd_q holds way cur_way
      ST_SCAN: begin
        if (act_q == ACT_FILL) begin
          if (!found_q && !rd_q.valid) begin
            found_d = 1'b1;
            hitf_d = 1'b0;
            sel_d = cur_way;
          end else if (!found_q && rd_q.stamp < best_q) begin
            best_d = rd_q.stamp;
            hitf_d = 1'b1;
            sel_d = cur_way;
            la_d = rd_q.addr;
            lv_d = rd_q.dirty;
          end
        end else if (!found_q && tag_match) begin
          found_d = 1'b1;
          sel_d = cur_way;
          la_d = rd_q.addr;
          lv_d = rd_q.dirty;
        end
        if (way_q == (WW+1)'(NUM_WAYS - 1)) begin
          state_d = ST_WRITE;
          re = 1'b1;
          raddr = line_of(set_q, sel_d);
        end else begin
          way_d = way_q + 1'b1;
          re = 1'b1;
          raddr = line_of(set_q, WW'(way_q + 1'b1));
        end
      end
      ST_WRITE: begin
        hit_d = 1'b0; lv_d = 1'b0; la_d = '0; ferr_d = 1'b0;
        if (act_q == ACT_FILL) begin
          if (found_q || hitf_q) begin
            we = 1'b1;
            wdata = '{valid: 1'b1, dirty: wr_q, tag: addr_q[31:TAG_LO],
                      addr: addr_q, stamp: now_q};
            if (!found_q && rd_q.dirty) begin
              lv_d = 1'b1;
              la_d = rd_q.addr;
            end
            if (wr_q) begin
              cnt_d = cnt_q + 1'b1;
              rset_d = 6'(set_q);
              rway_d = 3'(sel_q);
            end
          end else begin
            ferr_d = 1'b1;
          end
        end else if (found_q) begin
          we = 1'b1;
          hit_d = 1'b1;
          if (act_q == ACT_ACCESS) begin
            wdata.stamp = now_q;
            if (wr_q) begin
              wdata.dirty = 1'b1;
              cnt_d = cnt_q + 1'b1;
              rset_d = 6'(set_q);
              rway_d = 3'(sel_q);
            end
          end else begin
            wdata.valid = 1'b0;
            wdata.dirty = 1'b0;
            cnt_d = cnt_q - 1'b1;
            lv_d = 1'b1;
            la_d = rd_q.addr;
          end
        end
        ov_d = 1'b1;
        state_d = ST_OUT;
      end
      ST_OUT: begin
        state_d = ST_IDLE;
      end
      default: state_d = ST_IDLE;
    endcase
  end

  assign out_valid_o      = ov_q;
  assign hit_o            = hit_q;
  assign line_valid_o     = lv_q;
  assign line_address_o   = la_q;
  assign fill_error_o     = ferr_q;
  assign dirty_total_o    = cnt_q;
  assign last_dirty_set_o = rset_q;
  assign last_dirty_way_o = rway_q;

  `SALT_ASSERT(a_no_accept_busy, clk_i, rst_ni, !(accept && state_q != ST_IDLE),
               "transaction accepted while busy")
  `SALT_ASSERT(a_err_only_fill, clk_i, rst_ni, !(ov_q && ferr_q && hit_q),
               "fill error together with hit")
  `SALT_ASSERT_NEXT(a_write_gives_out, clk_i, rst_ni, state_q == ST_WRITE, ov_q,
                    "result missing after update")
  `SALT_ASSERT_NEXT(a_out_holds, clk_i, rst_ni, ov_q && out_stall_i,
                    ov_q && $stable(la_q) && $stable(cnt_q), "stalled result changed")

endmodule
